// File: rtl/ctc_pkg.sv
// Shared constants, codes and helper functions for the CCD charge-trail corrector.
// No dependencies; ctc_trail, the top level and ctc_checker import this package.
`timescale 1ns / 1ps

package ctc_pkg;

   // default geometry
   localparam int DEF_SEGMENT_COUNT       = 4;
   localparam int DEF_COLUMNS_PER_SEGMENT = 256;
   localparam int DEF_ROW_COUNT           = 1024;

   // fixed field widths
   localparam int HEIGHT_W   = 21;
   localparam int POS_W      = 14;
   localparam int AMT_W      = 30;
   localparam int TRAIL_W    = 32;
   localparam int ALPHA_W    = 16;
   localparam int OFFSET_W   = 12;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_USED_W = 5 * HEIGHT_W;

   // trail-amount pipeline: one stage per log2 fraction bit plus the tail
   localparam int LOG_STEPS = 16;
   localparam int TRAIL_LAT = LOG_STEPS + 10;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_CORRECT = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      PIDX_TRAIL_COL = 3'd0,
      PIDX_TRAIL_ROW = 3'd1,
      PIDX_ALPHA_COL = 3'd2,
      PIDX_ALPHA_ROW = 3'd3,
      PIDX_OFF_COL   = 3'd4,
      PIDX_OFF_ROW   = 3'd5
   } pidx_type;

   // log2 in Q.16 by repeated squaring, evaluated at elaboration only
   function automatic int lg_q16(input int unsigned v);
      longint unsigned m;
      int              e;
      int              frac;
      e    = 0;
      frac = 0;
      for (int b = 0; b < 32; b++) begin
         if (((v >> b) & 1) != 0) e = b;
      end
      m = longint'(v) << (30 - e);
      for (int k = 0; k < LOG_STEPS; k++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            frac = frac | 1;
            m    = m >> 1;
         end
      end
      return e * 65536 + frac;
   endfunction

   // log2 of 1500.0 given in Q.8, result in Q.16
   localparam int LG_REF = lg_q16(384000);

   // clamp to a 21-bit signed height
   function automatic logic signed [HEIGHT_W-1:0] sat21(input logic signed [31:0] v);
      logic signed [HEIGHT_W-1:0] r;
      if (v > 32'sd1048575) r = 21'sd1048575;
      else if (v < -32'sd1048576) r = -21'sd1048576;
      else r = v[HEIGHT_W-1:0];
      return r;
   endfunction

endpackage

// File: rtl/ctc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ctc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wen,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              ren,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ctc_trail.sv
// Pipelined trail-amount unit: log2 by squaring, power by polynomial exp2,
// then scaling by trail, position and height. Depends on ctc_pkg.
`timescale 1ns / 1ps

module ctc_trail #(
   parameter int CTX_W = 1
) (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [ctc_pkg::HEIGHT_W-1:0] h_in,
   input  logic [ctc_pkg::TRAIL_W-1:0]        trail_in,
   input  logic signed [ctc_pkg::ALPHA_W-1:0] alpha_in,
   input  logic signed [ctc_pkg::POS_W-1:0]   pos_in,
   input  logic [CTX_W-1:0]                   ctx_in,
   output logic signed [ctc_pkg::AMT_W-1:0]   amt_out,
   output logic [CTX_W-1:0]                   ctx_out
);
   import ctc_pkg::*;

   localparam int S_L   = LOG_STEPS + 1;
   localparam int S_Y   = LOG_STEPS + 2;
   localparam int S_Q1  = LOG_STEPS + 3;
   localparam int S_Q2  = LOG_STEPS + 4;
   localparam int S_P   = LOG_STEPS + 5;
   localparam int S_C   = LOG_STEPS + 6;
   localparam int S_SH  = LOG_STEPS + 7;
   localparam int S_F   = LOG_STEPS + 8;
   localparam int S_AMT = LOG_STEPS + 9;

   localparam logic signed [55:0] FR_CAP = 56'sd1099511627776;
   localparam logic [40:0]        C_CAP  = 41'd1 << 40;

   typedef struct packed {
      logic [CTX_W-1:0]            ctx;
      logic                        hpos;
      logic signed [HEIGHT_W-1:0]  h;
      logic [TRAIL_W-1:0]          trail;
      logic signed [ALPHA_W-1:0]   alpha;
      logic signed [POS_W-1:0]     pos;
      logic [4:0]                  e;
      logic [30:0]                 m;
      logic [15:0]                 frac;
      logic signed [22:0]          lval;
      logic signed [27:0]          y;
      logic [16:0]                 q;
      logic [40:0]                 c;
      logic signed [41:0]          fr;
      logic signed [AMT_W-1:0]     amt;
   } stage_type;

   stage_type stg_ff [TRAIL_LAT];
   stage_type stg_in [TRAIL_LAT];

   always_comb begin
      logic [19:0]        v;
      logic [4:0]         e;
      logic [61:0]        sq;
      logic [31:0]        t;
      logic signed [16:0] am;
      logic signed [39:0] prod;
      logic [15:0]        f;
      logic signed [11:0] n;
      logic [11:0]        nn;
      logic [40:0]        thr;
      logic signed [55:0] p56;
      logic signed [62:0] p63;
      sq = '0;
      t  = '0;

      // entry: leading-one search and mantissa normalization
      v = h_in[19:0];
      e = '0;
      for (int b = 0; b < 20; b++) begin
         if (v[b]) e = 5'(b);
      end
      stg_in[0]       = '0;
      stg_in[0].ctx   = ctx_in;
      stg_in[0].hpos  = !h_in[HEIGHT_W-1] && (h_in != '0);
      stg_in[0].h     = h_in;
      stg_in[0].trail = trail_in;
      stg_in[0].alpha = alpha_in;
      stg_in[0].pos   = pos_in;
      stg_in[0].e     = e;
      stg_in[0].m     = 31'({11'b0, v} << (5'd30 - e));

      // one fraction bit of log2 per stage
      for (int k = 1; k <= LOG_STEPS; k++) begin
         sq        = {31'b0, stg_ff[k-1].m} * {31'b0, stg_ff[k-1].m};
         t         = sq[61:30];
         stg_in[k] = stg_ff[k-1];
         if (t[31]) begin
            stg_in[k].m    = t[31:1];
            stg_in[k].frac = {stg_ff[k-1].frac[14:0], 1'b1};
         end else begin
            stg_in[k].m    = t[30:0];
            stg_in[k].frac = {stg_ff[k-1].frac[14:0], 1'b0};
         end
      end

      // log2 relative to 1500
      stg_in[S_L]      = stg_ff[S_L-1];
      stg_in[S_L].lval = $signed({2'b0, stg_ff[S_L-1].e, stg_ff[S_L-1].frac}) - 23'(LG_REF);

      // exponent (alpha - 1) times log, floor to Q.16
      stg_in[S_Y]   = stg_ff[S_Y-1];
      am            = {stg_ff[S_Y-1].alpha[ALPHA_W-1], stg_ff[S_Y-1].alpha} - 17'd4096;
      prod          = 40'(am) * 40'(stg_ff[S_Y-1].lval);
      stg_in[S_Y].y = prod[39:12];

      // exp2 of the fraction, Horner form over three stages
      stg_in[S_Q1]   = stg_ff[S_Q1-1];
      f              = stg_ff[S_Q1-1].y[15:0];
      stg_in[S_Q1].q = 17'((32'(f) * 32'd5206) >> 16);

      stg_in[S_Q2]   = stg_ff[S_Q2-1];
      f              = stg_ff[S_Q2-1].y[15:0];
      stg_in[S_Q2].q = 17'((33'(f) * 33'(17'd14712 + stg_ff[S_Q2-1].q)) >> 16);

      stg_in[S_P]   = stg_ff[S_P-1];
      f             = stg_ff[S_P-1].y[15:0];
      stg_in[S_P].q = 17'd65536
                    + 17'((33'(f) * 33'(17'd45617 + stg_ff[S_P-1].q)) >> 16);

      // trail times power
      stg_in[S_C]   = stg_ff[S_C-1];
      stg_in[S_C].c = 41'((49'(stg_ff[S_C-1].trail) * 49'(stg_ff[S_C-1].q)) >> 16);

      // integer part of the exponent, saturating left shift
      stg_in[S_SH] = stg_ff[S_SH-1];
      n            = stg_ff[S_SH-1].y[27:16];
      nn           = 12'(-n);
      thr          = '0;
      if (n > 0) begin
         if (n >= 41) begin
            stg_in[S_SH].c = (stg_ff[S_SH-1].c != '0) ? C_CAP : '0;
         end else begin
            thr = 41'd1 << (6'd40 - n[5:0]);
            if (stg_ff[S_SH-1].c > thr) begin
               stg_in[S_SH].c = C_CAP;
            end else begin
               stg_in[S_SH].c = stg_ff[S_SH-1].c << n[5:0];
            end
         end
      end else if (n < 0) begin
         if (nn >= 12'd41) stg_in[S_SH].c = '0;
         else stg_in[S_SH].c = stg_ff[S_SH-1].c >> nn[5:0];
      end

      // fraction times position, clamped to +-2^40
      stg_in[S_F] = stg_ff[S_F-1];
      p56         = 56'($signed({1'b0, stg_ff[S_F-1].c})) * 56'(stg_ff[S_F-1].pos);
      if (p56 > FR_CAP) stg_in[S_F].fr = 42'(FR_CAP);
      else if (p56 < -FR_CAP) stg_in[S_F].fr = 42'(-FR_CAP);
      else stg_in[S_F].fr = 42'(p56);

      // height times fraction, floor to Q.8; zero for non-positive height
      stg_in[S_AMT]     = stg_ff[S_AMT-1];
      p63               = 63'(stg_ff[S_AMT-1].h) * 63'(stg_ff[S_AMT-1].fr);
      stg_in[S_AMT].amt = stg_ff[S_AMT-1].hpos ? $signed(p63[61:32]) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < TRAIL_LAT; k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign amt_out = stg_ff[TRAIL_LAT-1].amt;
   assign ctx_out = stg_ff[TRAIL_LAT-1].ctx;

endmodule

// File: rtl/ccd_charge_trail_correction.sv
// Top level of the CCD charge-trail corrector: parameter tables, two correction passes.
// Depends on ctc_pkg, ctc_ram and ctc_trail.
`timescale 1ns / 1ps

// Usage
//  req_* carries requests. req_tuser = CMD_LOAD writes one parameter of the
//  per-column table at segment/column; CMD_CORRECT corrects one event and
//  yields one rsp_* item. Load requests give no response.
//  csr_wen/csr_wdata set the enable bit; write it only while the block is idle.
//  Throughput: one request per cycle while the response side is not stalled, loads and events mixed freely.
//  An accepted event passes the table read with stage A, the two 26-stage
//  trail units in series (each holding the 16-step log2 squaring chain),
//  stage B and the output register before it shows on rsp_tvalid.
//  A load is visible to an event accepted in the next cycle; tables sit in
//  six RAMs, whose registered read data lines up with stage A and feeds pass one.
//  Reset clears the valid pipeline and sets the enable bit; table contents are
//  undefined until loaded, and no clearing pass is run.
//  When rsp_tready is low with a response waiting, the whole pipeline holds
//  and req_tready drops; bubbles are not squeezed out.
module ccd_charge_trail_correction #(
   parameter int SEGMENT_COUNT       = ctc_pkg::DEF_SEGMENT_COUNT,
   parameter int COLUMNS_PER_SEGMENT = ctc_pkg::DEF_COLUMNS_PER_SEGMENT,
   parameter int ROW_COUNT           = ctc_pkg::DEF_ROW_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic                            csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // segment_id[1:0] column[9:2] row[19:10] param_index[22:20] param_value[54:23]
   // height_center[75:55] height_left[96:76] height_up[117:97]
   // height_right[138:118] height_down[159:139]
   input  logic [ctc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // command
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_center[20:0] out_left[41:21] out_up[62:42] out_right[83:63]
   // out_down[104:84], zeros above
   output logic [ctc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ctc_pkg::*;

   localparam int DEPTH  = SEGMENT_COUNT * COLUMNS_PER_SEGMENT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NSTG   = 2 * TRAIL_LAT + 3;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] hc;
      logic signed [HEIGHT_W-1:0] hl;
      logic signed [HEIGHT_W-1:0] hu;
      logic signed [HEIGHT_W-1:0] hr;
      logic signed [HEIGHT_W-1:0] hd;
   } hgt_type;

   typedef struct packed {
      logic [TRAIL_W-1:0]        tc;
      logic signed [ALPHA_W-1:0] ac;
      logic [TRAIL_W-1:0]        tr;
      logic signed [ALPHA_W-1:0] ar;
      logic signed [POS_W-1:0]   pos_r;
      logic signed [POS_W-1:0]   pos_d;
   } par_type;

   typedef struct packed {
      hgt_type    hgt;
      logic [7:0] colm;
      logic [9:0] rowm;
   } sta_type;

   typedef struct packed {
      hgt_type hgt;
      par_type par;
   } stb_type;

   // request fields
   logic [1:0]                seg;
   logic [7:0]                col;
   logic [9:0]                row;
   logic [2:0]                pidx;
   logic [31:0]               pval;
   hgt_type                   req_hgt;

   assign seg          = req_tdata[1:0];
   assign col          = req_tdata[9:2];
   assign row          = req_tdata[19:10];
   assign pidx         = req_tdata[22:20];
   assign pval         = req_tdata[54:23];
   assign req_hgt.hc   = req_tdata[75:55];
   assign req_hgt.hl   = req_tdata[96:76];
   assign req_hgt.hu   = req_tdata[117:97];
   assign req_hgt.hr   = req_tdata[138:118];
   assign req_hgt.hd   = req_tdata[159:139];

   // handshake and pipeline advance
   logic            adv;
   logic            acc;
   logic            ld;
   logic            ev_acc;
   logic [NSTG-1:0] vld_ff;
   logic            enable_ff;

   assign adv        = !vld_ff[NSTG-1] || rsp_tready;
   assign req_tready = adv;
   assign acc        = req_tvalid && adv;
   assign ld         = acc && (req_tuser == CMD_LOAD);
   assign ev_acc     = acc && (req_tuser == CMD_CORRECT);
   assign rsp_tvalid = vld_ff[NSTG-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         enable_ff <= 1'b1;
      end else begin
         if (adv) vld_ff <= {vld_ff[NSTG-2:0], ev_acc};
         if (csr_wen) enable_ff <= csr_wdata;
      end
   end

   // address folding tables (constants)
   logic [ADDR_W-1:0] seg_base [4];
   logic [7:0]        col_mod  [256];
   logic [11:0]       row_hi   [16];
   logic [11:0]       row_lo   [64];

   for (genvar g = 0; g < 4; g++) begin : g_seg
      assign seg_base[g] = ADDR_W'((g % SEGMENT_COUNT) * COLUMNS_PER_SEGMENT);
   end
   for (genvar g = 0; g < 256; g++) begin : g_col
      assign col_mod[g] = 8'(g % COLUMNS_PER_SEGMENT);
   end
   for (genvar g = 0; g < 16; g++) begin : g_rhi
      assign row_hi[g] = 12'((g * 64) % ROW_COUNT);
   end
   for (genvar g = 0; g < 64; g++) begin : g_rlo
      assign row_lo[g] = 12'(g % ROW_COUNT);
   end

   logic [7:0]        colm;
   logic [12:0]       row_sum;
   logic [12:0]       row_fold;
   logic [ADDR_W-1:0] addr;

   assign colm     = col_mod[col];
   assign row_sum  = 13'(row_hi[row[9:6]]) + 13'(row_lo[row[5:0]]);
   assign row_fold = (row_sum >= 13'(ROW_COUNT)) ? row_sum - 13'(ROW_COUNT) : row_sum;
   assign addr     = seg_base[seg] + ADDR_W'(colm);

   // parameter tables
   logic [TRAIL_W-1:0]  tc_rd;
   logic [TRAIL_W-1:0]  tr_rd;
   logic [ALPHA_W-1:0]  ac_rd;
   logic [ALPHA_W-1:0]  ar_rd;
   logic [OFFSET_W-1:0] oc_rd;
   logic [OFFSET_W-1:0] or_rd;

   ctc_ram #(.WIDTH(TRAIL_W), .DEPTH(DEPTH)) u_trail_col (
      .clock(clock), .wen(ld && (pidx == PIDX_TRAIL_COL)), .waddr(addr), .wdata(pval),
      .ren(adv), .raddr(addr), .rdata(tc_rd));
   ctc_ram #(.WIDTH(TRAIL_W), .DEPTH(DEPTH)) u_trail_row (
      .clock(clock), .wen(ld && (pidx == PIDX_TRAIL_ROW)), .waddr(addr), .wdata(pval),
      .ren(adv), .raddr(addr), .rdata(tr_rd));
   ctc_ram #(.WIDTH(ALPHA_W), .DEPTH(DEPTH)) u_alpha_col (
      .clock(clock), .wen(ld && (pidx == PIDX_ALPHA_COL)), .waddr(addr),
      .wdata(pval[ALPHA_W-1:0]), .ren(adv), .raddr(addr), .rdata(ac_rd));
   ctc_ram #(.WIDTH(ALPHA_W), .DEPTH(DEPTH)) u_alpha_row (
      .clock(clock), .wen(ld && (pidx == PIDX_ALPHA_ROW)), .waddr(addr),
      .wdata(pval[ALPHA_W-1:0]), .ren(adv), .raddr(addr), .rdata(ar_rd));
   ctc_ram #(.WIDTH(OFFSET_W), .DEPTH(DEPTH)) u_off_col (
      .clock(clock), .wen(ld && (pidx == PIDX_OFF_COL)), .waddr(addr),
      .wdata(pval[OFFSET_W-1:0]), .ren(adv), .raddr(addr), .rdata(oc_rd));
   ctc_ram #(.WIDTH(OFFSET_W), .DEPTH(DEPTH)) u_off_row (
      .clock(clock), .wen(ld && (pidx == PIDX_OFF_ROW)), .waddr(addr),
      .wdata(pval[OFFSET_W-1:0]), .ren(adv), .raddr(addr), .rdata(or_rd));

   // stage A: event fields, aligned with the table read
   sta_type a_ff;
   sta_type a_in;

   always_comb begin
      a_in.hgt  = req_hgt;
      a_in.colm = colm;
      a_in.rowm = row_fold[9:0];
   end

   always_ff @(posedge clock) begin
      if (adv) a_ff <= a_in;
   end

   // positions for both passes
   logic signed [POS_W-1:0] col_s;
   logic signed [POS_W-1:0] row_s;
   logic signed [POS_W-1:0] oc_s;
   logic signed [POS_W-1:0] or_s;
   logic signed [POS_W-1:0] pos_l;
   logic signed [POS_W-1:0] pos_u;
   par_type                 par_a;

   assign col_s = $signed({{(POS_W-8){1'b0}}, a_ff.colm});
   assign row_s = $signed({{(POS_W-10){1'b0}}, a_ff.rowm});
   assign oc_s  = $signed({{(POS_W-OFFSET_W){oc_rd[OFFSET_W-1]}}, oc_rd});
   assign or_s  = $signed({{(POS_W-OFFSET_W){or_rd[OFFSET_W-1]}}, or_rd});
   assign pos_l = col_s - 14'sd1 + oc_s;
   assign pos_u = row_s - 14'sd1 + or_s;

   always_comb begin
      par_a.tc    = tc_rd;
      par_a.ac    = ac_rd;
      par_a.tr    = tr_rd;
      par_a.ar    = ar_rd;
      par_a.pos_r = col_s + oc_s;
      par_a.pos_d = row_s + or_s;
   end

   // pass one: trail from left and up pixels
   logic signed [AMT_W-1:0] dl;
   logic signed [AMT_W-1:0] du;
   hgt_type                 hgt_1;
   par_type                 par_1;

   ctc_trail #(.CTX_W($bits(hgt_type))) u_trail_l (
      .clock(clock), .adv(adv), .h_in(a_ff.hgt.hl), .trail_in(tc_rd),
      .alpha_in($signed(ac_rd)), .pos_in(pos_l), .ctx_in(a_ff.hgt),
      .amt_out(dl), .ctx_out(hgt_1));

   ctc_trail #(.CTX_W($bits(par_type))) u_trail_u (
      .clock(clock), .adv(adv), .h_in(a_ff.hgt.hu), .trail_in(tr_rd),
      .alpha_in($signed(ar_rd)), .pos_in(pos_u), .ctx_in(par_a),
      .amt_out(du), .ctx_out(par_1));

   // stage B: pass-one update
   stb_type                 b_ff;
   stb_type                 b_in;
   logic signed [AMT_W-1:0] dl_e;
   logic signed [AMT_W-1:0] du_e;

   assign dl_e = enable_ff ? dl : '0;
   assign du_e = enable_ff ? du : '0;

   always_comb begin
      b_in.par    = par_1;
      b_in.hgt    = hgt_1;
      b_in.hgt.hl = sat21(32'(hgt_1.hl) + 32'(dl_e));
      b_in.hgt.hu = sat21(32'(hgt_1.hu) + 32'(du_e));
      b_in.hgt.hc = sat21(32'(hgt_1.hc) - 32'(dl_e) - 32'(du_e));
   end

   always_ff @(posedge clock) begin
      if (adv) b_ff <= b_in;
   end

   // pass two: trail from the centre height, added to the centre and taken from right and down pixels
   localparam int CTX_R_W = 3 * HEIGHT_W;
   localparam int CTX_D_W = 2 * HEIGHT_W;

   logic signed [AMT_W-1:0] dr;
   logic signed [AMT_W-1:0] dd;
   logic [CTX_R_W-1:0]      ctx_r;
   logic [CTX_D_W-1:0]      ctx_d;

   ctc_trail #(.CTX_W(CTX_R_W)) u_trail_r (
      .clock(clock), .adv(adv), .h_in(b_ff.hgt.hc), .trail_in(b_ff.par.tc),
      .alpha_in(b_ff.par.ac), .pos_in(b_ff.par.pos_r),
      .ctx_in({b_ff.hgt.hc, b_ff.hgt.hl, b_ff.hgt.hu}),
      .amt_out(dr), .ctx_out(ctx_r));

   ctc_trail #(.CTX_W(CTX_D_W)) u_trail_d (
      .clock(clock), .adv(adv), .h_in(b_ff.hgt.hc), .trail_in(b_ff.par.tr),
      .alpha_in(b_ff.par.ar), .pos_in(b_ff.par.pos_d),
      .ctx_in({b_ff.hgt.hr, b_ff.hgt.hd}),
      .amt_out(dd), .ctx_out(ctx_d));

   // output register: pass-two update
   hgt_type                 out_ff;
   hgt_type                 out_in;
   logic signed [AMT_W-1:0] dr_e;
   logic signed [AMT_W-1:0] dd_e;

   assign dr_e = enable_ff ? dr : '0;
   assign dd_e = enable_ff ? dd : '0;

   always_comb begin
      out_in.hc = sat21(32'($signed(ctx_r[3*HEIGHT_W-1:2*HEIGHT_W])) + 32'(dr_e) + 32'(dd_e));
      out_in.hl = ctx_r[2*HEIGHT_W-1:HEIGHT_W];
      out_in.hu = ctx_r[HEIGHT_W-1:0];
      out_in.hr = sat21(32'($signed(ctx_d[2*HEIGHT_W-1:HEIGHT_W])) - 32'(dr_e));
      out_in.hd = sat21(32'($signed(ctx_d[HEIGHT_W-1:0])) - 32'(dd_e));
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_tdata = {{(RSP_DATA_W-RSP_USED_W){1'b0}},
                       out_ff.hd, out_ff.hr, out_ff.hu, out_ff.hl, out_ff.hc};

endmodule

// File: rtl/ctc_checker.sv
// Port-level checks for the charge-trail corrector, bound to the top level.
// Depends on ctc_pkg and ccd_charge_trail_correction.
`timescale 1ns / 1ps

module ctc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ctc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ctc_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // empty output slot means requests are taken
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with output slot free");

   // a stalled response stalls the request side
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while output stalled");

   // padding above the five heights stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_USED_W] == '0)
      else $error("response padding not zero");

endmodule

bind ccd_charge_trail_correction ctc_checker u_ctc_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
